// ----- design/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and the control store of the min-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

    // Default number of heap entries.
    localparam int CAPACITY_DEF = 256;

    // Width of the count field in the result word.
    localparam int COUNT_W = 9;

    // Action codes of an input word.
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Status codes of a result word.
    localparam logic [1:0] STS_DONE  = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    // Input word.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] key;
        logic [15:0] payload;
    } in_word_t;

    // Result word.
    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        out_key;
        logic [15:0]        out_payload;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } out_word_t;

    // One heap entry as held in the store: cost above handle.
    typedef struct packed {
        logic [15:0] key;
        logic [15:0] payload;
    } heap_entry_t;

    // Datapath operations, one per microinstruction.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_PUSH,
        DP_RD_PARENT,
        DP_UP_STEP,
        DP_WR_ENT,
        DP_RD_ROOT,
        DP_RD_LAST,
        DP_LOAD_MOVED,
        DP_RD_LEFT,
        DP_RD_RIGHT,
        DP_DOWN_STEP,
        DP_SET_FULL,
        DP_SET_EMPTY,
        DP_CLEAR,
        DP_SKIP
    } dp_op_t;

    // Jump conditions.
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_ROOT,
        C_UP_GO,
        C_NO_LEFT,
        C_DOWN_GO
    } cond_t;

    // Datapath status seen by the sequencer.
    typedef struct packed {
        logic root;
        logic up_go;
        logic no_left;
        logic down_go;
        logic empty;
        logic full;
    } dp_flags_t;

    // Step addresses of the control store.
    typedef logic [4:0] upc_t;

    localparam upc_t U_IDLE    = 5'd0;
    localparam upc_t U_PUSH    = 5'd1;
    localparam upc_t U_P_RD    = 5'd2;
    localparam upc_t U_P_CMP   = 5'd3;
    localparam upc_t U_P_WR    = 5'd4;
    localparam upc_t U_POP     = 5'd5;
    localparam upc_t U_POP_LST = 5'd6;
    localparam upc_t U_POP_MOV = 5'd7;
    localparam upc_t U_D_RD    = 5'd8;
    localparam upc_t U_D_RGT   = 5'd9;
    localparam upc_t U_D_CMP   = 5'd10;
    localparam upc_t U_D_WR    = 5'd11;
    localparam upc_t U_FULL    = 5'd12;
    localparam upc_t U_EMPTY   = 5'd13;
    localparam upc_t U_CLEAR   = 5'd14;
    localparam upc_t U_SKIP    = 5'd15;
    localparam upc_t U_END     = 5'd16;

    // One control word.
    typedef struct packed {
        dp_op_t op;
        cond_t  cond;
        upc_t   target;
        logic   done;
    } ucode_t;

    // Control store. A step jumps to its target when its condition holds
    // and otherwise falls through to the next step.
    function automatic ucode_t mhpq_rom(input upc_t a);
        ucode_t w;
        begin
            case (a)
                U_IDLE:    w = '{DP_NOP,        C_ALWAYS,  U_IDLE, 1'b0};
                // Push: append, then sift up, reading the parent and comparing at each level.
                U_PUSH:    w = '{DP_LOAD_PUSH,  C_NEXT,    U_IDLE, 1'b0};
                U_P_RD:    w = '{DP_RD_PARENT,  C_ROOT,    U_P_WR, 1'b0};
                U_P_CMP:   w = '{DP_UP_STEP,    C_UP_GO,   U_P_RD, 1'b0};
                U_P_WR:    w = '{DP_WR_ENT,     C_ALWAYS,  U_END,  1'b0};
                // Pop: take the root, move the last entry in, sift down.
                U_POP:     w = '{DP_RD_ROOT,    C_NEXT,    U_IDLE, 1'b0};
                U_POP_LST: w = '{DP_RD_LAST,    C_NEXT,    U_IDLE, 1'b0};
                U_POP_MOV: w = '{DP_LOAD_MOVED, C_NEXT,    U_IDLE, 1'b0};
                U_D_RD:    w = '{DP_RD_LEFT,    C_NO_LEFT, U_D_WR, 1'b0};
                U_D_RGT:   w = '{DP_RD_RIGHT,   C_NEXT,    U_IDLE, 1'b0};
                U_D_CMP:   w = '{DP_DOWN_STEP,  C_DOWN_GO, U_D_RD, 1'b0};
                U_D_WR:    w = '{DP_WR_ENT,     C_ALWAYS,  U_END,  1'b0};
                // Short items.
                U_FULL:    w = '{DP_SET_FULL,   C_ALWAYS,  U_END,  1'b0};
                U_EMPTY:   w = '{DP_SET_EMPTY,  C_ALWAYS,  U_END,  1'b0};
                U_CLEAR:   w = '{DP_CLEAR,      C_ALWAYS,  U_END,  1'b0};
                U_SKIP:    w = '{DP_SKIP,       C_NEXT,    U_IDLE, 1'b0};
                U_END:     w = '{DP_NOP,        C_ALWAYS,  U_IDLE, 1'b1};
                default:   w = '{DP_NOP,        C_ALWAYS,  U_IDLE, 1'b0};
            endcase
            return w;
        end
    endfunction

endpackage

// ----- design/mhpq_dp.sv -----
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry store with one registered read port and one write
// port, position and count registers, and the cost comparators.
// ----------------------------------------------------------------------------
module mhpq_dp #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  mhpq_pkg::in_word_t    item,
    input  mhpq_pkg::dp_op_t      op,
    output mhpq_pkg::dp_flags_t   flags,
    output logic [1:0]            status,
    output mhpq_pkg::heap_entry_t top,
    output logic [CNT_W-1:0]      cnt
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    // Entry store; a child read past the last entry may fetch an unwritten entry, whose data is then not used.
    mhpq_pkg::heap_entry_t mem [CAPACITY];

    logic [CNT_W-1:0]      cnt_reg,  cnt_next;
    logic [CNT_W-1:0]      pos_reg,  pos_next;
    logic [1:0]            status_reg, status_next;
    mhpq_pkg::heap_entry_t top_reg,  top_next;
    mhpq_pkg::heap_entry_t ent_reg,  ent_next;
    mhpq_pkg::heap_entry_t cand_reg, cand_next;
    mhpq_pkg::heap_entry_t in_reg;
    mhpq_pkg::heap_entry_t rd_data_reg;
    logic                  has_r_reg, has_r_next;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  we;
    logic [AW-1:0]         wr_addr;
    mhpq_pkg::heap_entry_t wr_data;

    logic [CNT_W:0]        two_pos;
    logic                  take_r;
    mhpq_pkg::heap_entry_t sel;

    // Child position and the cheaper child.
    assign two_pos = {pos_reg, 1'b0};
    assign take_r  = has_r_reg && (rd_data_reg.key < cand_reg.key);
    assign sel     = take_r ? rd_data_reg : cand_reg;

    // Flags for the sequencer's jumps.
    always_comb
    begin
        flags.root    = (pos_reg == CNT_W'(1));
        flags.up_go   = (ent_reg.key < rd_data_reg.key);
        flags.no_left = (two_pos > {1'b0, cnt_reg});
        flags.down_go = !(ent_reg.key < sel.key);
        flags.empty   = (cnt_reg == '0);
        flags.full    = (cnt_reg >= CNT_W'(CAPACITY));
    end

    // Operation decode.
    always_comb
    begin
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        status_next = status_reg;
        top_next    = top_reg;
        ent_next    = ent_reg;
        cand_next   = cand_reg;
        has_r_next  = has_r_reg;
        rd_en       = 1'b0;
        rd_addr     = AW'(pos_reg - 1'b1);
        we          = 1'b0;
        wr_addr     = AW'(pos_reg - 1'b1);
        wr_data     = ent_reg;
        case (op)
            mhpq_pkg::DP_LOAD_PUSH:
            begin
                ent_next    = in_reg;
                cnt_next    = cnt_reg + 1'b1;
                pos_next    = cnt_reg + 1'b1;
                status_next = mhpq_pkg::STS_DONE;
                top_next    = '0;
            end
            mhpq_pkg::DP_RD_PARENT:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'((pos_reg >> 1) - 1'b1);
            end
            mhpq_pkg::DP_UP_STEP:
            begin
                if (flags.up_go)
                begin
                    we       = 1'b1;
                    wr_data  = rd_data_reg;
                    pos_next = pos_reg >> 1;
                end
            end
            mhpq_pkg::DP_WR_ENT:
            begin
                we = !flags.empty;
            end
            mhpq_pkg::DP_RD_ROOT:
            begin
                rd_en       = 1'b1;
                rd_addr     = '0;
                status_next = mhpq_pkg::STS_DONE;
            end
            mhpq_pkg::DP_RD_LAST:
            begin
                top_next = rd_data_reg;
                rd_en    = 1'b1;
                rd_addr  = AW'(cnt_reg - 1'b1);
                cnt_next = cnt_reg - 1'b1;
                pos_next = CNT_W'(1);
            end
            mhpq_pkg::DP_LOAD_MOVED:
            begin
                ent_next = rd_data_reg;
            end
            mhpq_pkg::DP_RD_LEFT:
            begin
                rd_en   = 1'b1;
                rd_addr = AW'(two_pos - 1'b1);
            end
            mhpq_pkg::DP_RD_RIGHT:
            begin
                cand_next  = rd_data_reg;
                has_r_next = (two_pos < {1'b0, cnt_reg});
                rd_en      = 1'b1;
                rd_addr    = AW'(two_pos);
            end
            mhpq_pkg::DP_DOWN_STEP:
            begin
                if (flags.down_go)
                begin
                    we       = 1'b1;
                    wr_data  = sel;
                    pos_next = CNT_W'(two_pos + (CNT_W + 1)'(take_r));
                end
            end
            mhpq_pkg::DP_SET_FULL:
            begin
                status_next = mhpq_pkg::STS_FULL;
                top_next    = '0;
            end
            mhpq_pkg::DP_SET_EMPTY:
            begin
                status_next = mhpq_pkg::STS_EMPTY;
                top_next    = '0;
            end
            mhpq_pkg::DP_CLEAR:
            begin
                cnt_next    = '0;
                status_next = mhpq_pkg::STS_DONE;
                top_next    = '0;
            end
            mhpq_pkg::DP_SKIP:
            begin
                status_next = mhpq_pkg::STS_DONE;
                top_next    = '0;
            end
            default:
            begin
            end
        endcase
    end

    // Entry count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Working registers and the input latch.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        status_reg <= status_next;
        top_reg    <= top_next;
        ent_reg    <= ent_next;
        cand_reg   <= cand_next;
        has_r_reg  <= has_r_next;
        if (take)
        begin
            in_reg <= '{key: item.key, payload: item.payload};
        end
    end

    // Store write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign status = status_reg;
    assign top    = top_reg;
    assign cnt    = cnt_reg;

endmodule

// ----- design/min_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue
// Binary min-heap of (cost, handle) entries run by a microcoded sequencer.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low; busy then stays high
// until the result word appears on result for one cycle with done high, and
// the receiver must take it in that cycle. The heap walk is limited by the
// single read port of the entry store, whose data is registered: a push
// reads the parent and compares at each level it rises, and a pop reads
// the left child, then the right child, and compares at each level it sinks.
// A new word may be started in the cycle its predecessor's result is shown.
// ----------------------------------------------------------------------------
module min_heap_priority_queue #(
    parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mhpq_pkg::in_word_t  item,
    output logic                done,
    output mhpq_pkg::out_word_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    mhpq_pkg::upc_t        upc_reg, upc_next;
    logic                  done_reg, done_next;
    mhpq_pkg::out_word_t   res_reg,  res_next;

    mhpq_pkg::ucode_t      uw;
    mhpq_pkg::dp_flags_t   flags;
    logic [1:0]            dp_status;
    mhpq_pkg::heap_entry_t dp_top;
    logic [CNT_W-1:0]      dp_cnt;
    logic                  take;
    logic                  jump;
    mhpq_pkg::upc_t        entry;

    assign busy = (upc_reg != mhpq_pkg::U_IDLE);
    assign take = start && !busy;
    assign uw   = mhpq_pkg::mhpq_rom(upc_reg);

    // Datapath and entry store.
    mhpq_dp #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (item),
        .op     (uw.op),
        .flags  (flags),
        .status (dp_status),
        .top    (dp_top),
        .cnt    (dp_cnt)
    );

    // Program entry point for an accepted word.
    always_comb
    begin
        case (item.action)
            mhpq_pkg::ACT_PUSH:  entry = flags.full  ? mhpq_pkg::U_FULL  : mhpq_pkg::U_PUSH;
            mhpq_pkg::ACT_POP:   entry = flags.empty ? mhpq_pkg::U_EMPTY : mhpq_pkg::U_POP;
            mhpq_pkg::ACT_CLEAR: entry = mhpq_pkg::U_CLEAR;
            default:             entry = mhpq_pkg::U_SKIP;
        endcase
    end

    // Jump condition of the current step.
    always_comb
    begin
        case (uw.cond)
            mhpq_pkg::C_ALWAYS:  jump = 1'b1;
            mhpq_pkg::C_ROOT:    jump = flags.root;
            mhpq_pkg::C_UP_GO:   jump = flags.up_go;
            mhpq_pkg::C_NO_LEFT: jump = flags.no_left;
            mhpq_pkg::C_DOWN_GO: jump = flags.down_go;
            default:             jump = 1'b0;
        endcase
    end

    // Step counter and result word.
    always_comb
    begin
        if (take)
        begin
            upc_next = entry;
        end
        else if (jump)
        begin
            upc_next = uw.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
        done_next            = uw.done;
        res_next             = res_reg;
        if (uw.done)
        begin
            res_next.status      = dp_status;
            res_next.out_key     = dp_top.key;
            res_next.out_payload = dp_top.payload;
            res_next.count       = mhpq_pkg::COUNT_W'(dp_cnt);
            res_next.empty_res   = flags.empty;
        end
    end

    // Sequencer state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg  <= mhpq_pkg::U_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            upc_reg  <= upc_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// ----- design/mhpq_checker.sv -----
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks of the min-heap priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module mhpq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input mhpq_pkg::out_word_t result
);

    // An accepted word keeps the block busy in the next cycle.
    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    // A result is shown only as the block goes idle after working on a word.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result shown outside the end of an item");

    // An item rejected with a full or empty status carries no entry.
    a_zero_entry: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status != mhpq_pkg::STS_DONE |->
            result.out_key == '0 && result.out_payload == '0)
        else $error("rejected item returned an entry");

    // A push rejected for lack of room leaves a non-empty heap.
    a_full_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == mhpq_pkg::STS_FULL |-> !result.empty_res)
        else $error("full status reported on an empty heap");

    // A pop on an empty heap leaves it empty.
    a_empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == mhpq_pkg::STS_EMPTY |-> result.empty_res)
        else $error("empty status reported on a non-empty heap");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);
